/* design/tdf_pkg.sv */
// Shared types and constants for the timed duplicate filter table.
package tdf_pkg;

  localparam int CALL_W = 42;
  localparam int SSID_W = 4;
  localparam int TYPE_W = 8;
  localparam int KEY_W  = CALL_W + SSID_W + TYPE_W;
  localparam int TIME_W = 32;
  localparam int WIN_W  = 16;
  localparam int SLOT_W = 6;
  localparam int ENT_W  = 1 + KEY_W + TIME_W;

  localparam logic [WIN_W-1:0] WIN_RESET = 16'd30;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_en;
    logic scan_start;
    logic scan_en;
    logic commit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_done;
    logic scan_done;
    logic out_free;
  } status_t;

endpackage

/* design/tdf_in_if.sv */
// Input channel: station key and current time.
interface tdf_in_if;
  logic                       valid;
  logic                       ready;
  logic [tdf_pkg::CALL_W-1:0] station_call;
  logic [tdf_pkg::SSID_W-1:0] station_ssid;
  logic [tdf_pkg::TYPE_W-1:0] packet_type;
  logic [tdf_pkg::TIME_W-1:0] now_secs;

  modport source (
    output valid, station_call, station_ssid, packet_type, now_secs,
    input  ready
  );
  modport sink (
    input  valid, station_call, station_ssid, packet_type, now_secs,
    output ready
  );
endinterface

/* design/tdf_out_if.sv */
// Output channel: duplicate flag and table slot.
interface tdf_out_if;
  logic                       valid;
  logic                       ready;
  logic                       is_duplicate;
  logic [tdf_pkg::SLOT_W-1:0] slot_used;

  modport source (
    output valid, is_duplicate, slot_used,
    input  ready
  );
  modport sink (
    input  valid, is_duplicate, slot_used,
    output ready
  );
endinterface

/* design/tdf_ctrl.sv */
// Controller state machine: clearing pass, accept, scan, commit.
module tdf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  tdf_pkg::status_t status,
  output tdf_pkg::cmd_t    cmd
);

  tdf_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tdf_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      tdf_pkg::ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (status.clr_done) begin
          state_next = tdf_pkg::ST_IDLE;
        end
      end
      tdf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.scan_start = 1'b1;
          state_next     = tdf_pkg::ST_SCAN;
        end
      end
      tdf_pkg::ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (status.scan_done) begin
          state_next = tdf_pkg::ST_FINISH;
        end
      end
      tdf_pkg::ST_FINISH: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = tdf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tdf_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

/* design/tdf_datapath.sv */
// Datapath: entry memory, scan counters, key compare, oldest search, result register.
module tdf_datapath #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  tdf_pkg::cmd_t              cmd,
  output tdf_pkg::status_t           status,
  input  logic [tdf_pkg::CALL_W-1:0] station_call,
  input  logic [tdf_pkg::SSID_W-1:0] station_ssid,
  input  logic [tdf_pkg::TYPE_W-1:0] packet_type,
  input  logic [tdf_pkg::TIME_W-1:0] now_secs,
  input  logic                       cfg_we,
  input  logic [tdf_pkg::WIN_W-1:0]  cfg_wdata,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       is_duplicate,
  output logic [tdf_pkg::SLOT_W-1:0] slot_used
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);
  localparam logic [CW-1:0] CNT_END  = CW'(TABLE_ENTRIES);

  // Entry memory: {valid, key, time}
  logic [tdf_pkg::ENT_W-1:0] mem [TABLE_ENTRIES];
  logic                      mem_we;
  logic [AW-1:0]             mem_wa;
  logic [tdf_pkg::ENT_W-1:0] mem_wd;
  logic [AW-1:0]             mem_ra;
  logic [tdf_pkg::ENT_W-1:0] rd_data;

  logic [tdf_pkg::WIN_W-1:0]  window;
  logic [tdf_pkg::KEY_W-1:0]  key_q;
  logic [tdf_pkg::TIME_W-1:0] now_q;
  logic [AW-1:0]              clr_cnt;
  logic [CW-1:0]              rd_cnt;
  logic                       rd_issue;
  logic                       rd_vld;
  logic [AW-1:0]              rd_idx;
  logic                       done;
  logic                       found;
  logic                       dup;
  logic [AW-1:0]              match_idx;
  logic [AW-1:0]              oldest;
  logic [tdf_pkg::TIME_W-1:0] min_time;

  logic                       e_valid;
  logic [tdf_pkg::KEY_W-1:0]  e_key;
  logic [tdf_pkg::TIME_W-1:0] e_time;
  logic [tdf_pkg::TIME_W-1:0] age;
  logic                       hit;
  logic [AW-1:0]              res_idx;
  logic                       out_take;

  assign {e_valid, e_key, e_time} = rd_data;
  assign hit      = e_valid && (e_key == key_q);
  assign age      = now_q - e_time;
  assign rd_issue = cmd.scan_en && (rd_cnt != CNT_END);
  assign mem_ra   = rd_cnt[AW-1:0];
  assign res_idx  = found ? match_idx : oldest;
  assign out_take = out_valid && out_ready;

  assign status.clr_done  = (clr_cnt == LAST_IDX);
  assign status.scan_done = done;
  assign status.out_free  = !out_valid || out_ready;

  // Write port select: clearing pass or commit
  always_comb begin
    mem_we = 1'b0;
    mem_wa = res_idx;
    mem_wd = {1'b1, key_q, now_q};
    if (cmd.clr_en) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt;
      mem_wd = '0;
    end else if (cmd.commit) begin
      mem_we = !(found && dup);
    end
  end

  // Memory ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[mem_ra];
  end

  // Window register
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= tdf_pkg::WIN_RESET;
    end else if (cfg_we) begin
      window <= cfg_wdata;
    end
  end

  // Item latch
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      key_q <= {station_call, station_ssid, packet_type};
      now_q <= now_secs;
    end
  end

  // Clear counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_en && !status.clr_done) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Read address counter and read-valid pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= rd_issue;
      if (cmd.scan_start) begin
        rd_cnt <= '0;
      end else if (rd_issue) begin
        rd_cnt <= rd_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= mem_ra;
  end

  // Scan evaluation: first hit ends it, else track first smallest time
  always_ff @(posedge clk) begin
    if (rst) begin
      done  <= 1'b0;
      found <= 1'b0;
    end else if (cmd.scan_start) begin
      done  <= 1'b0;
      found <= 1'b0;
    end else if (rd_vld && !done) begin
      if (hit) begin
        done  <= 1'b1;
        found <= 1'b1;
      end else if (rd_idx == LAST_IDX) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld && !done) begin
      if (hit) begin
        match_idx <= rd_idx;
        dup       <= (age < {{(tdf_pkg::TIME_W - tdf_pkg::WIN_W){1'b0}}, window});
      end else if ((rd_idx == '0) || (e_time < min_time)) begin
        min_time <= e_time;
        oldest   <= rd_idx;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      is_duplicate <= found && dup;
      slot_used    <= tdf_pkg::SLOT_W'(res_idx);
    end
  end

endmodule

/* design/timed_duplicate_filter_table.sv */
// Top level of the timed duplicate filter table.
//
//  Channel  Dir  Handshake          Contents
//  req      in   valid/ready        station_call, station_ssid, packet_type, now_secs
//  rsp      out  valid/ready        is_duplicate, slot_used
//  cfg      in   cfg_we             cfg_wdata -> dupe window (seconds)
//
// The scan reads one entry a cycle from the single-port-read entry memory and stops
// at the first key hit. After reset a clearing pass zeroes the memory; no
// transfer is taken on req during it. A waiting result on rsp holds the
// next item in its finish state until the result register frees up.
module timed_duplicate_filter_table #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  tdf_in_if.sink                    req,
  tdf_out_if.source                 rsp,
  input  logic                      cfg_we,
  input  logic [tdf_pkg::WIN_W-1:0] cfg_wdata
);

  tdf_pkg::cmd_t    cmd;
  tdf_pkg::status_t status;

  tdf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  tdf_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .station_call (req.station_call),
    .station_ssid (req.station_ssid),
    .packet_type  (req.packet_type),
    .now_secs     (req.now_secs),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .is_duplicate (rsp.is_duplicate),
    .slot_used    (rsp.slot_used)
  );

  // A commit only follows a finished scan
  a_commit_after_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> status.scan_done)
    else $error("commit without finished scan");

  // A commit never overruns a waiting result
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> status.out_free)
    else $error("commit while result register busy");

  // A commit shows a result next cycle
  a_commit_result: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> rsp.valid)
    else $error("result missing after commit");

  // Scans start only on an input transfer, never during clearing
  a_start_on_transfer: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_start |-> (req.valid && req.ready && !cmd.clr_en))
    else $error("scan started without transfer");

endmodule

/* tb/sv/timed_duplicate_filter_table_tb.sv */
// Self-checking testbench for the timed duplicate filter table.
module timed_duplicate_filter_table_tb;

  localparam int ENTRIES     = 64;
  localparam int IDLE_LIMIT  = 4000;
  localparam int LONG_HOLD   = 500;
  localparam int HOLD_AFTER  = 60;

  typedef struct {
    logic [tdf_pkg::CALL_W-1:0] call;
    logic [tdf_pkg::SSID_W-1:0] ssid;
    logic [tdf_pkg::TYPE_W-1:0] ptype;
    logic [tdf_pkg::TIME_W-1:0] now_s;
  } station_item_t;

  typedef struct {
    logic                       dup;
    logic [tdf_pkg::SLOT_W-1:0] slot;
  } filter_result_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [tdf_pkg::WIN_W-1:0] cfg_wdata;

  tdf_in_if  req_if ();
  tdf_out_if rsp_if ();

  timed_duplicate_filter_table #(
    .TABLE_ENTRIES(ENTRIES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_if),
    .rsp      (rsp_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Stations waiting to be sent and verdicts waiting to come back
  station_item_t  pending_stations[$];
  filter_result_t expected_verdicts[$];
  int             mismatches;

  // Shadow copy of the timestamp table and the window
  logic                       shadow_valid [ENTRIES];
  logic [tdf_pkg::KEY_W-1:0]  shadow_key   [ENTRIES];
  logic [tdf_pkg::TIME_W-1:0] shadow_time  [ENTRIES];
  logic [tdf_pkg::WIN_W-1:0]  window_q;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Look up one station in the shadow table and update it as the block would
  function automatic filter_result_t filter_station(logic [tdf_pkg::KEY_W-1:0] key,
                                                    logic [tdf_pkg::TIME_W-1:0] now_s);
    filter_result_t r;
    logic [tdf_pkg::TIME_W-1:0] age;
    int oldest;
    oldest = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (shadow_valid[i] && shadow_key[i] == key) begin
        age = now_s - shadow_time[i];
        if (age < tdf_pkg::TIME_W'(window_q)) begin
          r.dup = 1'b1;
        end else begin
          r.dup = 1'b0;
          shadow_time[i] = now_s;
        end
        r.slot = tdf_pkg::SLOT_W'(i);
        return r;
      end
      if (shadow_time[i] < shadow_time[oldest]) oldest = i;
    end
    // Miss: the first entry with the smallest time takes the key
    shadow_valid[oldest] = 1'b1;
    shadow_key[oldest]   = key;
    shadow_time[oldest]  = now_s;
    r.dup  = 1'b0;
    r.slot = tdf_pkg::SLOT_W'(oldest);
    return r;
  endfunction

  // Track window writes and predict a verdict for every input transfer
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        shadow_valid[i] = 1'b0;
        shadow_key[i]   = '0;
        shadow_time[i]  = '0;
      end
      window_q = tdf_pkg::WIN_RESET;
    end else begin
      if (cfg_we) window_q = cfg_wdata;
      if (req_if.valid && req_if.ready) begin
        expected_verdicts.push_back(filter_station(
            {req_if.station_call, req_if.station_ssid, req_if.packet_type},
            req_if.now_secs));
      end
    end
  end

  // Driver: bursts of stations with random gaps
  int            burst_left;
  int            gap_left;
  station_item_t next_station;

  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!req_if.valid || req_if.ready) begin
      if (gap_left > 0) begin
        gap_left--;
        req_if.valid <= 1'b0;
      end else if (pending_stations.size() > 0) begin
        next_station = pending_stations.pop_front();
        req_if.station_call <= next_station.call;
        req_if.station_ssid <= next_station.ssid;
        req_if.packet_type  <= next_station.ptype;
        req_if.now_secs     <= next_station.now_s;
        req_if.valid        <= 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern of its own, plus one long hold-off
  int       results_taken;
  int       hold_left;
  int       run_left;
  bit       long_hold_done;
  rx_mode_t rx_mode;

  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
      results_taken  = 0;
      hold_left      = 0;
      run_left       = 0;
      long_hold_done = 1'b0;
      rx_mode        = RX_OPEN;
    end else begin
      if (rsp_if.valid && rsp_if.ready) results_taken++;
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (!long_hold_done && results_taken >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD;
        rsp_if.ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          rx_mode  = rx_mode_t'($urandom_range(0, 3));
          run_left = $urandom_range(4, 60);
        end else begin
          run_left--;
        end
        case (rx_mode)
          RX_OPEN:   rsp_if.ready <= 1'b1;
          RX_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: rsp_if.ready <= ($urandom_range(0, 3) == 0);
          default:   rsp_if.ready <= (run_left % 3 != 0);
        endcase
      end
    end
  end

  // Monitor: compare each result transfer with the oldest prediction
  filter_result_t want;

  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (expected_verdicts.size() == 0) begin
        $error("unexpected result: is_duplicate=%0d slot_used=%0d",
               rsp_if.is_duplicate, rsp_if.slot_used);
        mismatches++;
      end else begin
        want = expected_verdicts.pop_front();
        if (rsp_if.is_duplicate !== want.dup) begin
          $error("is_duplicate: expected %0d, got %0d", want.dup, rsp_if.is_duplicate);
          mismatches++;
        end
        if (rsp_if.slot_used !== want.slot) begin
          $error("slot_used: expected %0d, got %0d", want.slot, rsp_if.slot_used);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  int idle_cycles;

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timed_duplicate_filter_table_tb NOT OK");
        $finish;
      end
    end
  end

  // Pack an ASCII callsign, space padded, first character on top
  function automatic logic [tdf_pkg::CALL_W-1:0] pack_call(string s);
    logic [tdf_pkg::CALL_W-1:0] c;
    c = '0;
    for (int i = 0; i < 6; i++) begin
      c = {c[tdf_pkg::CALL_W-8:0], (i < s.len()) ? 7'(s[i]) : 7'h20};
    end
    return c;
  endfunction

  function automatic logic [tdf_pkg::KEY_W-1:0] random_key();
    logic [tdf_pkg::CALL_W-1:0] c;
    int len;
    if ($urandom_range(0, 1) == 0) begin
      c = {10'($urandom), 32'($urandom)};
    end else begin
      // Callsign-like: letters and digits, trailing spaces
      len = $urandom_range(3, 6);
      c = '0;
      for (int i = 0; i < 6; i++) begin
        if (i >= len) c = {c[tdf_pkg::CALL_W-8:0], 7'h20};
        else if (i == 2)
          c = {c[tdf_pkg::CALL_W-8:0], 7'(8'h30 + $urandom_range(0, 9))};
        else c = {c[tdf_pkg::CALL_W-8:0], 7'(8'h41 + $urandom_range(0, 25))};
      end
    end
    return {c, 4'($urandom), ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom)};
  endfunction

  task automatic push_station(logic [tdf_pkg::CALL_W-1:0] call,
                              logic [tdf_pkg::SSID_W-1:0] ssid,
                              logic [tdf_pkg::TYPE_W-1:0] ptype,
                              logic [tdf_pkg::TIME_W-1:0] now_s);
    station_item_t s;
    s.call  = call;
    s.ssid  = ssid;
    s.ptype = ptype;
    s.now_s = now_s;
    pending_stations.push_back(s);
  endtask

  task automatic push_key(logic [tdf_pkg::KEY_W-1:0] key,
                          logic [tdf_pkg::TIME_W-1:0] now_s);
    push_station(key[tdf_pkg::KEY_W-1 -: tdf_pkg::CALL_W],
                 key[tdf_pkg::SSID_W+tdf_pkg::TYPE_W-1 -: tdf_pkg::SSID_W],
                 key[tdf_pkg::TYPE_W-1:0], now_s);
  endtask

  // Sender pause: nothing queued, nothing offered, nothing outstanding
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_stations.size() != 0 || req_if.valid || expected_verdicts.size() != 0);
  endtask

  task automatic write_window(logic [tdf_pkg::WIN_W-1:0] win);
    wait_drained();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= win;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One random phase: a pool of repeating stations on a mostly rising clock
  task automatic run_phase(logic [tdf_pkg::WIN_W-1:0] win, int pool_n, int step_max,
                           int count, logic [tdf_pkg::TIME_W-1:0] start, bit pause_mid);
    logic [tdf_pkg::KEY_W-1:0]  pool[$];
    logic [tdf_pkg::KEY_W-1:0]  key;
    logic [tdf_pkg::TIME_W-1:0] now_t;
    int r;
    write_window(win);
    for (int i = 0; i < pool_n; i++) begin
      // Some pool keys differ from an earlier one only in SSID or type
      if (i > 0 && $urandom_range(0, 4) == 0) begin
        key = pool[$urandom_range(0, i - 1)];
        if ($urandom_range(0, 1) == 0)
          key[tdf_pkg::SSID_W+tdf_pkg::TYPE_W-1 -: tdf_pkg::SSID_W] = 4'($urandom);
        else key[tdf_pkg::TYPE_W-1:0] = 8'($urandom);
      end else begin
        key = random_key();
      end
      pool.push_back(key);
    end
    now_t = start;
    for (int n = 0; n < count; n++) begin
      if (pause_mid && n == count / 2) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 4) now_t = now_t - $urandom_range(1, 1000);
      else if (r < 7) now_t = now_t + $urandom_range(60000, 300000);
      else now_t = now_t + $urandom_range(0, step_max);
      if ($urandom_range(0, 9) == 0) key = random_key();
      else key = pool[$urandom_range(0, pool_n - 1)];
      push_key(key, now_t);
    end
  endtask

  // Reset, directed cases, random phases, end of run
  initial begin
    logic [tdf_pkg::CALL_W-1:0] c_call;
    logic [tdf_pkg::CALL_W-1:0] w_call;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    req_if.valid        = 1'b0;
    req_if.station_call = '0;
    req_if.station_ssid = '0;
    req_if.packet_type  = '0;
    req_if.now_secs     = '0;
    rsp_if.ready        = 1'b0;
    mismatches          = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    c_call = pack_call("N0CALL");
    w_call = pack_call("WIDE");

    // Default window: first use, tie on time zero, duplicate, window edge
    push_station('0, '0, '0, 32'd0);
    push_station('1, 4'hF, 8'hFF, 32'd0);       // replaces the valid entry at time 0
    push_station('1, 4'hF, 8'hFF, 32'd10);      // duplicate
    push_station('1, 4'hF, 8'hFF, 32'd40);      // aged out, refreshed
    push_station(c_call, 4'd0, 8'h21, 32'd69);  // miss into the empty entry
    push_station('1, 4'hF, 8'hFF, 32'd69);      // age one below the window
    push_station('1, 4'hF, 8'hFF, 32'd70);      // age equal to the window
    push_station('1, 4'hF, 8'hFF, 32'd20);      // time going backwards
    push_station(c_call, 4'd9, 8'h21, 32'd20);  // differs only in SSID
    push_station(c_call, 4'd0, 8'h3E, 32'd20);  // differs only in type
    push_station(w_call, 4'd1, 8'h3D, 32'hFFFF_FFFF);
    push_station(w_call, 4'd1, 8'h3D, 32'd10);  // age wraps past 2^32
    push_station(c_call, 4'd0, 8'h21, 32'd100);

    // Zero window: nothing is a duplicate
    write_window('0);
    push_station(c_call, 4'd0, 8'h21, 32'd100);
    push_station(c_call, 4'd0, 8'h21, 32'd100);

    // Widest window
    write_window('1);
    push_station(c_call, 4'd0, 8'h21, 32'd65634);
    push_station(c_call, 4'd0, 8'h21, 32'd65635);

    run_phase(tdf_pkg::WIN_RESET, 12, 8, 160, 32'($urandom), 1'b0);
    run_phase(16'd1, 40, 2, 140, 32'($urandom), 1'b0);
    run_phase(16'd0, 8, 3, 120, 32'($urandom), 1'b1);
    run_phase('1, 90, 500, 160, 32'($urandom), 1'b0);
    run_phase(16'($urandom), 30, 3000, 140, 32'($urandom), 1'b0);
    run_phase(16'($urandom_range(2, 200)), 70, 20, 160, 32'hFFFF_FF00, 1'b0);

    // Let any stray result show up before deciding
    wait_drained();
    repeat (ENTRIES + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("timed_duplicate_filter_table_tb OK");
    end else begin
      $display("timed_duplicate_filter_table_tb NOT OK");
    end
    $finish;
  end

endmodule

/* timed_duplicate_filter_table.f */
design/tdf_pkg.sv
design/tdf_in_if.sv
design/tdf_out_if.sv
design/tdf_ctrl.sv
design/tdf_datapath.sv
design/timed_duplicate_filter_table.sv
tb/sv/timed_duplicate_filter_table_tb.sv
